// ===== rtl/core/json_string_unescape_utf8_core_macros.svh =====
// Assertion macros for the JSON string unescaper core.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JSU_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg)
`define JSU_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/core/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper core.
package jsu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [3:0]  error_code;
        logic [31:0] error_offset;
        logic        last_of_run;
    } out_beat_t;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] ERR_EXPECTED_STRING = 4'd0;
    localparam logic [3:0] ERR_CONTROL_CHAR    = 4'd1;
    localparam logic [3:0] ERR_TRUNC_ESCAPE    = 4'd2;
    localparam logic [3:0] ERR_BAD_ESCAPE      = 4'd3;
    localparam logic [3:0] ERR_TRUNC_UNICODE   = 4'd4;
    localparam logic [3:0] ERR_BAD_HEX         = 4'd5;
    localparam logic [3:0] ERR_MISSING_LOW     = 4'd6;
    localparam logic [3:0] ERR_BAD_LOW         = 4'd7;
    localparam logic [3:0] ERR_LONE_LOW        = 4'd8;
    localparam logic [3:0] ERR_UNTERMINATED    = 4'd9;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS_OUT = 8'h08;
    localparam logic [7:0] CH_FF_OUT = 8'h0C;
    localparam logic [7:0] CH_LF_OUT = 8'h0A;

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h10000;
    localparam logic [20:0] CP_MAX_1BYTE  = 21'h00007F;
    localparam logic [20:0] CP_MAX_2BYTE  = 21'h0007FF;
    localparam logic [20:0] CP_MAX_3BYTE  = 21'h00FFFF;
    localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD4    = 8'hF0;
    localparam logic [7:0]  UTF8_CONT     = 8'h80;

endpackage

// ===== rtl/core/json_string_unescape_utf8_core.sv =====
// Pipeline: a source byte is captured in the input register and decoded there; its result
// run is registered into the run buffer that drives the output (a stalled run holds the byte).
// Throughput: one source byte per cycle while each byte gives at most one result and res_stall
// is low; a byte that gives several results (up to five, for a 4-byte UTF-8 sequence plus an
// error) holds the decode stage while the output counter drains the run.
// Reset (rst_n low, asynchronous) returns to idle and clears the byte counter; no clearing pass.
`include "json_string_unescape_utf8_core_macros.svh"

module json_string_unescape_utf8_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  jsu_pkg::in_beat_t  src_beat,
    output logic               res_valid,
    input  logic               res_stall,
    output jsu_pkg::out_beat_t res_beat
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_BODY    = 3'd1;
    localparam logic [2:0] M_ESC     = 3'd2;
    localparam logic [2:0] M_HEX_HI  = 3'd3;
    localparam logic [2:0] M_WANT_BS = 3'd4;
    localparam logic [2:0] M_WANT_U  = 3'd5;
    localparam logic [2:0] M_HEX_LO  = 3'd6;

    // input register
    logic     in_valid_reg;
    in_beat_t in_beat_reg;

    // decode state
    logic [2:0]             mode_reg, mode_next;
    logic [15:0]            acc_reg, acc_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   bad_reg, bad_next;
    logic [1:0]             bidx_reg, bidx_next;
    logic [9:0]             hs_reg, hs_next;
    logic [OFFSET_BITS-1:0] byte_count_reg;

    // result run buffer
    logic [7:0]  run_bytes_reg [4];
    logic [7:0]  run_bytes_next [4];
    logic [2:0]  run_nb_reg, run_nb_next;
    logic [2:0]  run_total_reg, run_total_next;
    logic [2:0]  run_idx_reg;
    logic [1:0]  tail_kind_reg, tail_kind_next;
    logic [3:0]  tail_code_reg, tail_code_next;
    logic [31:0] tail_off_reg, tail_off_next;

    logic pop, pop_last, process;

    logic [7:0]             c;
    logic                   last;
    logic [OFFSET_BITS-1:0] n_cnt, prev_cnt;

    // hex digit step
    logic       hex_ok;
    logic [3:0] hex_nib;
    logic [15:0] dig_acc;
    logic       dig_bad;
    logic [1:0] dig_bidx;
    logic [2:0] dig_got;
    logic       dig_full;
    logic [20:0] lo_cp, hi_cp, cp_sel;

    // utf8 encoder
    logic [7:0] u8_bytes [4];
    logic [2:0] u8_len;

    // decode results
    logic                   emit1;
    logic [7:0]             emit1_byte;
    logic                   emit_cp;
    logic                   fail_en;
    logic [3:0]             fail_code;
    logic [OFFSET_BITS-1:0] fail_off;
    logic                   done_en;
    logic                   esc_hit;
    logic [7:0]             esc_byte;
    logic                   is_ws;

    assign c        = in_beat_reg.data_byte;
    assign last     = in_beat_reg.end_of_input;
    assign prev_cnt = byte_count_reg;
    assign n_cnt    = byte_count_reg + OFFSET_BITS'(1);

    // Handshake
    assign res_valid = (run_idx_reg != run_total_reg);
    assign pop       = res_valid && !res_stall;
    assign pop_last  = pop && (run_idx_reg == (run_total_reg - 3'd1));
    assign process   = in_valid_reg && (!res_valid || pop_last);
    assign src_stall = in_valid_reg && !process;

    always_comb
    begin
        res_beat = '0;
        if (run_idx_reg < run_nb_reg)
        begin
            res_beat.kind     = KIND_BYTE;
            res_beat.out_byte = run_bytes_reg[run_idx_reg[1:0]];
        end
        else
        begin
            res_beat.kind         = tail_kind_reg;
            res_beat.error_code   = tail_code_reg;
            res_beat.error_offset = tail_off_reg;
        end
        res_beat.last_of_run = (run_idx_reg == (run_total_reg - 3'd1));
    end

    // Hex digit datapath
    always_comb
    begin
        hex_ok  = 1'b0;
        hex_nib = 4'hF;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_ok  = 1'b1;
            hex_nib = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            hex_ok  = 1'b1;
            hex_nib = c[3:0] + 4'd9;
        end
    end

    assign dig_acc  = {acc_reg[11:0], hex_nib};
    assign dig_bad  = bad_reg || !hex_ok;
    assign dig_bidx = (!bad_reg && !hex_ok) ? cnt_reg : bidx_reg;
    assign dig_got  = {1'b0, cnt_reg} + 3'd1;
    assign dig_full = (cnt_reg == 2'd3);
    assign hi_cp    = {5'd0, dig_acc};
    assign lo_cp    = CP_SUPP_BASE + {1'b0, hs_reg, dig_acc[9:0]};
    assign cp_sel   = (mode_reg == M_HEX_LO) ? lo_cp : hi_cp;

    // UTF-8 encoder
    always_comb
    begin
        u8_bytes[0] = '0;
        u8_bytes[1] = '0;
        u8_bytes[2] = '0;
        u8_bytes[3] = '0;
        priority if (cp_sel <= CP_MAX_1BYTE)
        begin
            u8_len      = 3'd1;
            u8_bytes[0] = cp_sel[7:0];
        end
        else if (cp_sel <= CP_MAX_2BYTE)
        begin
            u8_len      = 3'd2;
            u8_bytes[0] = UTF8_LEAD2 | {3'd0, cp_sel[10:6]};
            u8_bytes[1] = UTF8_CONT | {2'd0, cp_sel[5:0]};
        end
        else if (cp_sel <= CP_MAX_3BYTE)
        begin
            u8_len      = 3'd3;
            u8_bytes[0] = UTF8_LEAD3 | {4'd0, cp_sel[15:12]};
            u8_bytes[1] = UTF8_CONT | {2'd0, cp_sel[11:6]};
            u8_bytes[2] = UTF8_CONT | {2'd0, cp_sel[5:0]};
        end
        else
        begin
            u8_len      = 3'd4;
            u8_bytes[0] = UTF8_LEAD4 | {5'd0, cp_sel[20:18]};
            u8_bytes[1] = UTF8_CONT | {2'd0, cp_sel[17:12]};
            u8_bytes[2] = UTF8_CONT | {2'd0, cp_sel[11:6]};
            u8_bytes[3] = UTF8_CONT | {2'd0, cp_sel[5:0]};
        end
    end

    assign is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);

    // Simple escapes
    always_comb
    begin
        esc_hit  = 1'b1;
        esc_byte = c;
        unique case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
            CH_LOW_B: esc_byte = CH_BS_OUT;
            CH_LOW_F: esc_byte = CH_FF_OUT;
            CH_LOW_N: esc_byte = CH_LF_OUT;
            CH_LOW_R: esc_byte = CH_CR;
            CH_LOW_T: esc_byte = CH_TAB;
            default:  esc_hit  = 1'b0;
        endcase
    end

    // Decode one source byte
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        bidx_next  = bidx_reg;
        hs_next    = hs_reg;
        emit1      = 1'b0;
        emit1_byte = c;
        emit_cp    = 1'b0;
        fail_en    = 1'b0;
        fail_code  = ERR_EXPECTED_STRING;
        fail_off   = n_cnt;
        done_en    = 1'b0;

        unique case (mode_reg)
            M_IDLE:
            begin
                priority if (is_ws)
                begin
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_EXPECTED_STRING;
                    end
                end
                else if (c == CH_QUOTE)
                begin
                    mode_next = M_BODY;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNTERMINATED;
                    end
                end
                else
                begin
                    // byte is not consumed: report the offset before it
                    fail_en   = 1'b1;
                    fail_code = ERR_EXPECTED_STRING;
                    fail_off  = prev_cnt;
                end
            end
            M_BODY:
            begin
                priority if (c == CH_QUOTE)
                begin
                    done_en = 1'b1;
                end
                else if (c < CH_SPACE)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_CONTROL_CHAR;
                end
                else if (c == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_TRUNC_ESCAPE;
                    end
                end
                else
                begin
                    emit1 = 1'b1;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNTERMINATED;
                    end
                end
            end
            M_ESC:
            begin
                priority if (c == CH_LOW_U)
                begin
                    mode_next = M_HEX_HI;
                    acc_next  = '0;
                    cnt_next  = '0;
                    bad_next  = 1'b0;
                    bidx_next = '0;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_TRUNC_UNICODE;
                    end
                end
                else if (esc_hit)
                begin
                    emit1      = 1'b1;
                    emit1_byte = esc_byte;
                    mode_next  = M_BODY;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_UNTERMINATED;
                    end
                end
                else
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_BAD_ESCAPE;
                end
            end
            M_HEX_HI, M_HEX_LO:
            begin
                acc_next  = dig_acc;
                bad_next  = dig_bad;
                bidx_next = dig_bidx;
                priority if (!dig_full)
                begin
                    cnt_next = dig_got[1:0];
                    if (last)
                    begin
                        // offset just after the 'u'
                        fail_en   = 1'b1;
                        fail_code = ERR_TRUNC_UNICODE;
                        fail_off  = n_cnt - OFFSET_BITS'(dig_got);
                    end
                end
                else if (dig_bad)
                begin
                    cnt_next  = '0;
                    fail_en   = 1'b1;
                    fail_code = ERR_BAD_HEX;
                    fail_off  = n_cnt - OFFSET_BITS'(2'd3 - dig_bidx);
                end
                else if (mode_reg == M_HEX_HI)
                begin
                    cnt_next = '0;
                    priority if (dig_acc[15:10] == SURR_HIGH_TAG)
                    begin
                        hs_next   = dig_acc[9:0];
                        mode_next = M_WANT_BS;
                        if (last)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_MISSING_LOW;
                        end
                    end
                    else if (dig_acc[15:10] == SURR_LOW_TAG)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_LONE_LOW;
                    end
                    else
                    begin
                        emit_cp   = 1'b1;
                        mode_next = M_BODY;
                        if (last)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_UNTERMINATED;
                        end
                    end
                end
                else
                begin
                    cnt_next = '0;
                    if (dig_acc[15:10] != SURR_LOW_TAG)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_BAD_LOW;
                    end
                    else
                    begin
                        emit_cp   = 1'b1;
                        mode_next = M_BODY;
                        if (last)
                        begin
                            fail_en   = 1'b1;
                            fail_code = ERR_UNTERMINATED;
                        end
                    end
                end
            end
            M_WANT_BS:
            begin
                if (c != CH_BSLASH || last)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_MISSING_LOW;
                    fail_off  = prev_cnt;
                end
                else
                begin
                    mode_next = M_WANT_U;
                end
            end
            M_WANT_U:
            begin
                if (c != CH_LOW_U)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_MISSING_LOW;
                    fail_off  = n_cnt - OFFSET_BITS'(2);
                end
                else
                begin
                    mode_next = M_HEX_LO;
                    acc_next  = '0;
                    cnt_next  = '0;
                    bad_next  = 1'b0;
                    bidx_next = '0;
                    if (last)
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_TRUNC_UNICODE;
                    end
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                acc_next  = '0;
                cnt_next  = '0;
                bad_next  = 1'b0;
                bidx_next = '0;
                hs_next   = '0;
            end
        endcase

        // Finished or failed: drop back to idle
        if (fail_en || done_en)
        begin
            mode_next = M_IDLE;
            acc_next  = '0;
            cnt_next  = '0;
            bad_next  = 1'b0;
            bidx_next = '0;
            hs_next   = '0;
        end
    end

    // Assemble the run of results for this byte
    always_comb
    begin
        if (emit1)
        begin
            run_bytes_next[0] = emit1_byte;
            run_bytes_next[1] = '0;
            run_bytes_next[2] = '0;
            run_bytes_next[3] = '0;
            run_nb_next       = 3'd1;
        end
        else
        begin
            run_bytes_next = u8_bytes;
            run_nb_next    = emit_cp ? u8_len : 3'd0;
        end
        tail_kind_next = fail_en ? KIND_ERROR : KIND_DONE;
        tail_code_next = fail_en ? fail_code : 4'd0;
        tail_off_next  = fail_en ? 32'(fail_off) : 32'd0;
        run_total_next = run_nb_next + {2'd0, (fail_en || done_en)};
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_beat_reg <= src_beat;
        end
    end

    // Decode state and run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            bad_reg        <= 1'b0;
            bidx_reg       <= '0;
            hs_reg         <= '0;
            byte_count_reg <= '0;
            run_total_reg  <= '0;
            run_idx_reg    <= '0;
            run_nb_reg     <= '0;
        end
        else if (process)
        begin
            mode_reg       <= mode_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            bad_reg        <= bad_next;
            bidx_reg       <= bidx_next;
            hs_reg         <= hs_next;
            byte_count_reg <= n_cnt;
            run_total_reg  <= run_total_next;
            run_idx_reg    <= '0;
            run_nb_reg     <= run_nb_next;
        end
        else if (pop)
        begin
            run_idx_reg <= run_idx_reg + 3'd1;
        end
    end

    // Run payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            run_bytes_reg <= run_bytes_next;
            tail_kind_reg <= tail_kind_next;
            tail_code_reg <= tail_code_next;
            tail_off_reg  <= tail_off_next;
        end
    end

    `JSU_ASSERT(a_idx_in_run, clk, rst_n,
        res_valid |-> (run_idx_reg < run_total_reg), "run index past end of run")
    `JSU_ASSERT(a_tail_is_last, clk, rst_n,
        (res_valid && res_beat.kind != KIND_BYTE) |-> res_beat.last_of_run,
        "done or error beat not last of run")
    `JSU_ASSERT(a_fail_to_idle, clk, rst_n,
        (process && fail_en) |=> (mode_reg == M_IDLE), "error did not return decoder to idle")
    `JSU_ASSERT(a_idle_clean, clk, rst_n,
        (mode_reg == M_IDLE) |-> (acc_reg == '0 && cnt_reg == '0 && !bad_reg && hs_reg == '0),
        "idle with stale escape state")

endmodule
